// File: rtl/msct_pkg.sv
// Shared constants, types and helpers for the countdown timer table.
`default_nettype none
package msct_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int TIME_WIDTH = 32;
  localparam int ID_W       = 32;
  localparam int MSG_W      = 32;
  localparam int DUR_IN_W   = 32;
  localparam int PERIOD_W   = 32;
  localparam int OP_W       = 3;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CMP_W  = (TIME_WIDTH > PERIOD_W) ? TIME_WIDTH : PERIOD_W;
  localparam int REC_W  = MSG_W + ID_W + 2 * TIME_WIDTH;

  localparam logic [PERIOD_W-1:0] TICK_RESET = PERIOD_W'(100);

  localparam logic RK_EXPIRED = 1'b0;
  localparam logic RK_FULL    = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_ADD    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_UPDATE = 3'd3,
    OP_RELOAD = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH,
    S_DROP
  } state_t;

  typedef enum logic [1:0] {
    WR_NEW,
    WR_SET,
    WR_RELOAD,
    WR_DEC
  } wr_mode_t;

  typedef enum logic {
    OUT_PEND,
    OUT_DROP
  } out_src_t;

  typedef struct packed {
    logic     load;
    logic     step;
    logic     wr_en;
    wr_mode_t wr_mode;
    logic     set_valid;
    logic     clr_valid;
    logic     clr_all;
    logic     pend_load;
    logic     out_load;
    out_src_t out_src;
    logic     out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ev_valid;
    logic            ev_last;
    logic            id_match;
    logic            expire;
    logic            pend_v;
    logic            out_free;
  } dp_status_t;

  function automatic logic [TIME_WIDTH-1:0] to_time(input logic [DUR_IN_W-1:0] d);
    logic [CMP_W-1:0] t;
    t = CMP_W'(d);
    return t[TIME_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/msct_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module msct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic                                      rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/msct_ctrl.sv
// Sequencer for the slot walk: accepts commands and drives the datapath.
`default_nettype none
module msct_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [msct_pkg::OP_W-1:0]   in_op,
  output logic                             in_ready,
  input  wire msct_pkg::dp_status_t        st,
  output msct_pkg::dp_cmd_t                cmd
);

  msct_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msct_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      msct_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_op == msct_pkg::OP_CLEAR) begin
            cmd.clr_all = 1'b1;
          end else if (in_op inside {msct_pkg::OP_TICK, msct_pkg::OP_ADD,
                                     msct_pkg::OP_REMOVE, msct_pkg::OP_UPDATE,
                                     msct_pkg::OP_RELOAD}) begin
            state_next = msct_pkg::S_WALK;
          end
        end
      end
      msct_pkg::S_WALK: begin
        case (st.op)
          msct_pkg::OP_TICK: begin
            if (st.ev_valid && st.expire) begin
              // hold back one expiry so the last one can carry tlast
              if (!st.pend_v || st.out_free) begin
                cmd.step      = 1'b1;
                cmd.clr_valid = 1'b1;
                cmd.pend_load = 1'b1;
                if (st.pend_v) begin
                  cmd.out_load = 1'b1;
                  cmd.out_src  = msct_pkg::OUT_PEND;
                  cmd.out_last = 1'b0;
                end
                if (st.ev_last) begin
                  state_next = msct_pkg::S_FLUSH;
                end
              end
            end else begin
              cmd.step = 1'b1;
              if (st.ev_valid) begin
                cmd.wr_en   = 1'b1;
                cmd.wr_mode = msct_pkg::WR_DEC;
              end
              if (st.ev_last) begin
                state_next = st.pend_v ? msct_pkg::S_FLUSH : msct_pkg::S_IDLE;
              end
            end
          end
          msct_pkg::OP_ADD: begin
            if (!st.ev_valid) begin
              cmd.wr_en     = 1'b1;
              cmd.wr_mode   = msct_pkg::WR_NEW;
              cmd.set_valid = 1'b1;
              state_next    = msct_pkg::S_IDLE;
            end else if (st.ev_last) begin
              state_next = msct_pkg::S_DROP;
            end else begin
              cmd.step = 1'b1;
            end
          end
          msct_pkg::OP_REMOVE, msct_pkg::OP_UPDATE, msct_pkg::OP_RELOAD: begin
            if (st.ev_valid && st.id_match) begin
              if (st.op == msct_pkg::OP_REMOVE) begin
                cmd.clr_valid = 1'b1;
              end else begin
                cmd.wr_en   = 1'b1;
                cmd.wr_mode = (st.op == msct_pkg::OP_UPDATE) ? msct_pkg::WR_SET
                                                             : msct_pkg::WR_RELOAD;
              end
              state_next = msct_pkg::S_IDLE;
            end else if (st.ev_last) begin
              state_next = msct_pkg::S_IDLE;
            end else begin
              cmd.step = 1'b1;
            end
          end
          default: begin
            state_next = msct_pkg::S_IDLE;
          end
        endcase
      end
      msct_pkg::S_FLUSH: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = msct_pkg::OUT_PEND;
          cmd.out_last = 1'b1;
          state_next   = msct_pkg::S_IDLE;
        end
      end
      msct_pkg::S_DROP: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = msct_pkg::OUT_DROP;
          cmd.out_last = 1'b1;
          state_next   = msct_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = msct_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == msct_pkg::S_IDLE) |-> !st.pend_v)
    else $error("pending expiry left over in idle");

  a_drop_only_add: assert property (@(posedge clk) disable iff (rst)
    (state == msct_pkg::S_DROP) |-> (st.op == msct_pkg::OP_ADD))
    else $error("table-full result for a command other than add");

  a_load_in_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == msct_pkg::S_IDLE))
    else $error("beat accepted while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("undelivered result overwritten");
`endif

endmodule
`default_nettype wire

// File: rtl/msct_datapath.sv
// Slot storage, period register, pending expiry and output register.
`default_nettype none
module msct_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire msct_pkg::dp_cmd_t               cmd,
  output msct_pkg::dp_status_t                 st,
  input  wire logic                            cfg_wr_en,
  input  wire logic [msct_pkg::PERIOD_W-1:0]   cfg_wr_data,
  input  wire logic [msct_pkg::OP_W-1:0]       in_op,
  input  wire logic [msct_pkg::ID_W-1:0]       in_id,
  input  wire logic [msct_pkg::DUR_IN_W-1:0]   in_dur,
  input  wire logic [msct_pkg::MSG_W-1:0]      in_msg,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_kind,
  output logic      [msct_pkg::ID_W-1:0]       out_id,
  output logic      [msct_pkg::MSG_W-1:0]      out_msg,
  output logic                                 out_last
);

  localparam int TW = msct_pkg::TIME_WIDTH;

  logic [msct_pkg::OP_W-1:0]     op_q;
  logic [msct_pkg::ID_W-1:0]     id_q;
  logic [TW-1:0]                 dur_q;
  logic [msct_pkg::MSG_W-1:0]    msg_q;
  logic [msct_pkg::PERIOD_W-1:0] tick_period;
  logic [msct_pkg::SLOT_COUNT-1:0] valid;
  logic [msct_pkg::SLOT_W-1:0]   ev_idx;
  logic                          pend_v;
  logic [msct_pkg::ID_W-1:0]     pend_id;
  logic [msct_pkg::MSG_W-1:0]    pend_msg;

  logic                          rd_en;
  logic [msct_pkg::SLOT_W-1:0]   rd_addr;
  logic [msct_pkg::REC_W-1:0]    rd_data;
  logic [msct_pkg::REC_W-1:0]    wr_data;

  logic [TW-1:0]                 ev_rem;
  logic [TW-1:0]                 ev_dur;
  logic [msct_pkg::ID_W-1:0]     ev_id;
  logic [msct_pkg::MSG_W-1:0]    ev_msg;
  logic [msct_pkg::CMP_W-1:0]    rem_diff;
  logic                          ev_last;
  logic                          out_free;

  // record: message, ident, duration, remaining (remaining lowest)
  assign ev_rem = rd_data[TW-1:0];
  assign ev_dur = rd_data[2*TW-1:TW];
  assign ev_id  = rd_data[2*TW+msct_pkg::ID_W-1:2*TW];
  assign ev_msg = rd_data[msct_pkg::REC_W-1:2*TW+msct_pkg::ID_W];

  assign ev_last  = (ev_idx == msct_pkg::SLOT_W'(msct_pkg::SLOT_COUNT - 1));
  assign rem_diff = msct_pkg::CMP_W'(ev_rem) - msct_pkg::CMP_W'(tick_period);
  assign out_free = !out_valid || out_ready;

  assign rd_en   = cmd.load || (cmd.step && !ev_last);
  assign rd_addr = cmd.load ? '0 : msct_pkg::SLOT_W'(ev_idx + 1'b1);

  always_comb begin
    case (cmd.wr_mode)
      msct_pkg::WR_NEW:    wr_data = {msg_q, id_q, dur_q, dur_q};
      msct_pkg::WR_SET:    wr_data = {ev_msg, ev_id, dur_q, dur_q};
      msct_pkg::WR_RELOAD: wr_data = {ev_msg, ev_id, ev_dur, ev_dur};
      msct_pkg::WR_DEC:    wr_data = {ev_msg, ev_id, ev_dur, rem_diff[TW-1:0]};
      default:             wr_data = {ev_msg, ev_id, ev_dur, ev_rem};
    endcase
  end

  msct_ram #(
    .WIDTH(msct_pkg::REC_W),
    .DEPTH(msct_pkg::SLOT_COUNT)
  ) u_slots (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (ev_idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    st          = '0;
    st.op       = op_q;
    st.ev_valid = valid[ev_idx];
    st.ev_last  = ev_last;
    st.id_match = (ev_id == id_q);
    st.expire   = (msct_pkg::CMP_W'(ev_rem) < msct_pkg::CMP_W'(tick_period));
    st.pend_v   = pend_v;
    st.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_op;
      id_q  <= in_id;
      dur_q <= msct_pkg::to_time(in_dur);
      msg_q <= in_msg;
    end
    if (cmd.load) begin
      ev_idx <= '0;
    end else if (cmd.step) begin
      ev_idx <= msct_pkg::SLOT_W'(ev_idx + 1'b1);
    end
    if (cmd.pend_load) begin
      pend_id  <= ev_id;
      pend_msg <= ev_msg;
    end
    if (cmd.out_load) begin
      out_last <= cmd.out_last;
      if (cmd.out_src == msct_pkg::OUT_DROP) begin
        out_kind <= msct_pkg::RK_FULL;
        out_id   <= id_q;
        out_msg  <= msg_q;
      end else begin
        out_kind <= msct_pkg::RK_EXPIRED;
        out_id   <= pend_id;
        out_msg  <= pend_msg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= msct_pkg::TICK_RESET;
      valid       <= '0;
      pend_v      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tick_period <= cfg_wr_data;
      end
      if (cmd.clr_all) begin
        valid <= '0;
      end else if (cmd.set_valid) begin
        valid[ev_idx] <= 1'b1;
      end else if (cmd.clr_valid) begin
        valid[ev_idx] <= 1'b0;
      end
      if (cmd.pend_load) begin
        pend_v <= 1'b1;
      end else if (cmd.out_load && cmd.out_src == msct_pkg::OUT_PEND) begin
        pend_v <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/multi_slot_countdown_timer_table.sv
// Top level of the multi-slot countdown timer table.
//
// Input beats on s_axis carry a command in tuser (tick, add, remove,
// update, reload, clear) with timer ID, duration and message in tdata.
// Results leave on m_axis: tuser is the kind (expired or table full),
// tdata holds ID and message, tlast marks the final result of a command.
// tick_period is written through cfg_wr_en / cfg_wr_data; the user must
// do so only while idle, the block itself does not enforce it. Each
// command except clear and unknown codes walks the slot RAM one slot per
// cycle unless a tick waits for m_axis, the next record read while
// the current one is updated: a tick visits every slot, then flushes its
// final expiry, if any; an add or a match stops at the first hit, and an
// add to a full table ends in a table-full result. The single read port
// of the slot RAM sets the rate. An expiry is held until the next expiry
// or the end of the walk settles its tlast, then moves to the output
// register. If m_axis stalls with a result held, a tick pauses at its
// next expiry while another is pending, until the result is taken; other
// slots are unaffected. Reset (rst, synchronous) empties the table,
// drops any held result and loads tick_period with 100.
`default_nettype none
module multi_slot_countdown_timer_table (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [2:0]   s_axis_tuser,   // command
  input  wire logic [95:0]  s_axis_tdata,   // timer_id, duration, message_value
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [0:0]        m_axis_tuser,   // result_kind
  output logic [63:0]       m_axis_tdata,   // expired_id, expired_message
  output logic              m_axis_tlast,
  input  wire logic         cfg_wr_en,
  input  wire logic [31:0]  cfg_wr_data
);

  msct_pkg::dp_cmd_t    cmd;
  msct_pkg::dp_status_t st;

  logic [msct_pkg::ID_W-1:0]  res_id;
  logic [msct_pkg::MSG_W-1:0] res_msg;
  logic                       res_kind;

  msct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  msct_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_op       (s_axis_tuser),
    .in_id       (s_axis_tdata[31:0]),
    .in_dur      (s_axis_tdata[63:32]),
    .in_msg      (s_axis_tdata[95:64]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_kind    (res_kind),
    .out_id      (res_id),
    .out_msg     (res_msg),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tuser = res_kind;
  assign m_axis_tdata = {res_msg, res_id};

endmodule
`default_nettype wire

// File: tb/timer_scoreboard_pkg.sv
// Scoreboard for the countdown timer table: slot predictor and expected report queue.
`timescale 1ns / 100ps
package timer_scoreboard_pkg;
  import msct_pkg::*;

  typedef struct {
    logic             kind;
    logic [ID_W-1:0]  ident;
    logic [MSG_W-1:0] msg;
    logic             last;
  } timer_report_t;

  class expiry_scoreboard;
    logic [PERIOD_W-1:0]   period;
    bit                    slot_used [SLOT_COUNT];
    logic [ID_W-1:0]       slot_id   [SLOT_COUNT];
    logic [TIME_WIDTH-1:0] slot_dur  [SLOT_COUNT];
    logic [TIME_WIDTH-1:0] slot_left [SLOT_COUNT];
    logic [MSG_W-1:0]      slot_msg  [SLOT_COUNT];
    timer_report_t         due_reports[$];
    int                    mismatches;

    function new();
      period = TICK_RESET;
      mismatches = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function void set_period(logic [PERIOD_W-1:0] p);
      period = p;
    endfunction

    function int pending();
      return due_reports.size();
    endfunction

    function int find_slot(logic [ID_W-1:0] ident);
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (slot_used[i] && slot_id[i] == ident) return i;
      end
      return -1;
    endfunction

    function void push_report(logic kind, logic [ID_W-1:0] ident, logic [MSG_W-1:0] msg);
      timer_report_t rpt;
      rpt.kind = kind;
      rpt.ident = ident;
      rpt.msg = msg;
      rpt.last = 1'b0;
      due_reports.push_back(rpt);
    endfunction

    // Predict the reports caused by one accepted command beat.
    function void note_command(logic [OP_W-1:0] cmd, logic [ID_W-1:0] ident,
                               logic [DUR_IN_W-1:0] dur, logic [MSG_W-1:0] msg);
      int hit;
      int base;
      logic [TIME_WIDTH-1:0] t;
      t = TIME_WIDTH'(dur);
      base = due_reports.size();
      hit = -1;
      case (cmd)
        OP_TICK: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_used[i]) begin
              if (CMP_W'(slot_left[i]) < CMP_W'(period)) begin
                slot_used[i] = 1'b0;
                push_report(RK_EXPIRED, slot_id[i], slot_msg[i]);
              end else begin
                slot_left[i] = slot_left[i] - TIME_WIDTH'(period);
              end
            end
          end
        end
        OP_ADD: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!slot_used[i]) begin
              hit = i;
              break;
            end
          end
          if (hit >= 0) begin
            slot_used[hit] = 1'b1;
            slot_id[hit] = ident;
            slot_dur[hit] = t;
            slot_left[hit] = t;
            slot_msg[hit] = msg;
          end else begin
            push_report(RK_FULL, ident, msg);
          end
        end
        OP_REMOVE: begin
          hit = find_slot(ident);
          if (hit >= 0) slot_used[hit] = 1'b0;
        end
        OP_UPDATE: begin
          hit = find_slot(ident);
          if (hit >= 0) begin
            slot_dur[hit] = t;
            slot_left[hit] = t;
          end
        end
        OP_RELOAD: begin
          hit = find_slot(ident);
          if (hit >= 0) slot_left[hit] = slot_dur[hit];
        end
        OP_CLEAR: begin
          foreach (slot_used[i]) slot_used[i] = 1'b0;
        end
        default: ;
      endcase
      if (due_reports.size() > base) due_reports[due_reports.size()-1].last = 1'b1;
    endfunction

    function void check_result(logic kind, logic [ID_W-1:0] ident, logic [MSG_W-1:0] msg,
                               logic last);
      timer_report_t want;
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected report kind=%0b id=%h msg=%h last=%0b",
                   $realtime, kind, ident, msg, last);
        return;
      end
      want = due_reports.pop_front();
      if (want.kind !== kind || want.ident !== ident || want.msg !== msg ||
          want.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: report mismatch exp kind=%0b id=%h msg=%h last=%0b, got kind=%0b id=%h msg=%h last=%0b",
                   $realtime, want.kind, want.ident, want.msg, want.last,
                   kind, ident, msg, last);
      end
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
// Top-level testbench for the countdown timer table: stimulus, stalls and final verdict.
`timescale 1ns / 100ps
module tb_top;
  import msct_pkg::*;
  import timer_scoreboard_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd7;

  localparam int RESET_CYCLES = 6;
  localparam int LONG_STALL   = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT   = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [2:0]  s_axis_tuser = '0;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [0:0]  m_axis_tuser;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  expiry_scoreboard sb;
  logic [31:0] cur_period = TICK_RESET;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int run_left = 0;
  logic run_ready = 1'b1;
  bit long_stall_req = 1'b0;

  multi_slot_countdown_timer_table uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #10 clk = ~clk;

  // Result side: check each beat, then pick the next ready level.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast);
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (long_stall_req) begin
      long_stall_req = 1'b0;
      stall_left = LONG_STALL;
      m_axis_tready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            run_ready = 1'b1;
            run_left = 40;
          end
          2, 3, 4, 5, 6: begin
            run_ready = 1'b1;
            run_left = $urandom_range(1, 6);
          end
          default: begin
            run_ready = 1'b0;
            run_left = $urandom_range(1, 8);
          end
        endcase
      end
      run_left--;
      m_axis_tready <= run_ready;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_command(input logic [2:0] cmd, input logic [31:0] ident,
                              input logic [31:0] dur, input logic [31:0] msg);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {msg, dur, ident};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_command(cmd, ident, dur, msg);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [31:0] p);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_period(p);
    cur_period = p;
  endtask

  function automatic logic [31:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return $urandom_range(0, 7);
    if (r == 8) return $urandom;
    return 32'hFFFF_FFFF;
  endfunction

  // Durations cluster around multiples of the period so ticks hit the boundary.
  function automatic logic [31:0] pick_duration(input logic [31:0] p);
    logic [63:0] d;
    if ($urandom_range(0, 6) == 0) return $urandom;
    d = 64'($urandom_range(0, 6)) * 64'(p);
    case ($urandom_range(0, 2))
      0: if (d != 0) d = d - 1;
      2: d = d + 1;
      default: ;
    endcase
    if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
    return d[31:0];
  endfunction

  task automatic send_random(input int count);
    int r;
    logic [2:0] cmd;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 33) cmd = OP_ADD;
      else if (r < 58) cmd = OP_TICK;
      else if (r < 68) cmd = OP_REMOVE;
      else if (r < 78) cmd = OP_UPDATE;
      else if (r < 88) cmd = OP_RELOAD;
      else if (r < 92) cmd = OP_CLEAR;
      else if (r < 96) cmd = OP_RSVD_A;
      else cmd = OP_RSVD_B;
      send_command(cmd, pick_id(), pick_duration(cur_period), $urandom);
    end
  endtask

  initial begin
    logic [31:0] periods [5];
    sb = new();
    periods[0] = 32'd1;
    periods[1] = 32'd0;
    periods[2] = 32'hFFFF_FFFF;
    periods[3] = $urandom_range(2, 1000);
    periods[4] = TICK_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: empty tick, extremes, duplicates, match misses, spare codes
    send_command(OP_TICK, 32'd0, 32'd0, 32'd0);
    send_command(OP_ADD, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_command(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_command(OP_ADD, 32'd5, 32'd150, 32'hA5A5_A5A5);
    send_command(OP_ADD, 32'd5, 32'd350, 32'h5A5A_5A5A);
    send_command(OP_TICK, 32'd0, 32'd0, 32'd0);
    send_command(OP_UPDATE, 32'd5, 32'd99, 32'd0);
    send_command(OP_RELOAD, 32'd5, 32'd0, 32'd0);
    send_command(OP_REMOVE, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_command(OP_REMOVE, 32'h0000_1234, 32'd0, 32'd0);
    send_command(OP_RSVD_A, 32'd5, 32'd0, 32'd0);
    send_command(OP_RSVD_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(OP_TICK, 32'd0, 32'd0, 32'd0);
    send_command(OP_CLEAR, 32'd0, 32'd0, 32'd0);
    wait_drained();

    // output held off while the table fills, overflows and fully expires
    long_stall_req = 1'b1;
    for (int i = 0; i < SLOT_COUNT; i++)
      send_command(OP_ADD, 32'h100 + i, 32'd0, $urandom);
    send_command(OP_ADD, 32'hDEAD_0001, 32'd7, 32'h0BAD_F00D);
    send_command(OP_TICK, 32'd0, 32'd0, 32'd0);
    send_random(60);

    foreach (periods[k]) begin
      wait_drained();
      write_period(periods[k]);
      send_random(56);
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/msct_pkg.sv
rtl/msct_ram.sv
rtl/msct_ctrl.sv
rtl/msct_datapath.sv
rtl/multi_slot_countdown_timer_table.sv
tb/timer_scoreboard_pkg.sv
tb/tb_top.sv
